// ===== hw/rtl/bba_pkg.sv =====
// Shared constants and types of the buddy block allocator.
`default_nettype none

package bba_pkg;

    localparam int ADDR_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int ORDER_W   = 5;
    localparam int HDR_W     = 7;

    typedef logic [1:0] status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NO_SPACE = 2'd1;
    localparam status_t ST_BAD_FREE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd1;

    localparam logic [HDR_W-1:0] HEADER_RESET = 7'd16;

endpackage

`default_nettype wire

// ===== hw/rtl/bba_ram.sv =====
// Simple dual-port synchronous RAM with one write port and a registered read port.
`default_nettype none

module bba_ram #(
    parameter int DW    = 8,
    parameter int AW    = 4,
    parameter int DEPTH = 16
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: request sequencer and the two state memories.
`default_nettype none

// Buddy allocator over a heap of 2^HEAP_ORDER bytes, blocks of 2^MIN_ORDER bytes and up.
// Requests enter on the s_ channel: s_tuser[0] is the operation (0 allocate, 1 free),
// s_tdata holds request_bytes in [31:0] and payload_address in [63:32]. One result
// item per request leaves on the m_ channel: m_tuser carries the status, m_tdata the
// result address in [31:0] and the block order in [36:32].
// The buddy tree lives in a memory with one word per node; each word is a bit mask of
// the orders that are free somewhere in that node's subtree, so the lowest-address
// free block of an order is found by one descent from the root. A second memory holds
// the order of the allocated block at each minimum-sized slot.
// One request is handled at a time. An allocate either ends early with no space, or
// descends from the root to a free block, splits it down to the needed order and then
// updates the path back to the root. A free either ends early as a bad free, or walks
// up merging with free buddies and then updates the path back to the root. The block
// is ready for the next item once the result is in the output register.
// After reset the block clears the order memory with s_tready low; the configuration
// port is taken during that time as always. A finished result sits in the output
// register while the next item is accepted; if the receiver stalls and a second result
// is ready, the block holds it and stops accepting until the first result is taken.
// Configuration must be written only while the block is idle; the block does not enforce it.
module buddy_block_allocator #(
    parameter int HEAP_ORDER = 16,
    parameter int MIN_ORDER  = 5
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wr_data,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // request_bytes [31:0], payload_address [63:32]
    input  wire logic [0:0]  s_tuser,   // operation [0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // result_address [31:0], block_order [36:32], zero pad
    output logic      [1:0]  m_tuser    // status [1:0]
);

    localparam int LEVELS = HEAP_ORDER - MIN_ORDER;
    localparam int NW     = LEVELS + 1;
    localparam int MW     = LEVELS + 1;
    localparam int LFW    = (LEVELS > 0) ? LEVELS : 1;
    localparam int LVW    = (LEVELS > 0) ? $clog2(LEVELS + 1) : 1;
    localparam int NODES  = (2 ** NW) - 1;
    localparam int LEAVES = 2 ** LEVELS;
    localparam int CW     = LEVELS + 1;
    localparam int OW     = bba_pkg::ORDER_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_AFIT  = 4'd3;
    localparam logic [3:0] S_AROOT = 4'd4;
    localparam logic [3:0] S_DESC  = 4'd5;
    localparam logic [3:0] S_DESCW = 4'd6;
    localparam logic [3:0] S_SPLIT = 4'd7;
    localparam logic [3:0] S_UPRD  = 4'd8;
    localparam logic [3:0] S_UPWR  = 4'd9;
    localparam logic [3:0] S_FCHK  = 4'd10;
    localparam logic [3:0] S_FORD  = 4'd11;
    localparam logic [3:0] S_MRD   = 4'd12;
    localparam logic [3:0] S_MWR   = 4'd13;
    localparam logic [3:0] S_MSET  = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    // Control state.
    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] heap_base_reg, heap_base_next;
    logic [6:0]  header_reg, header_next;

    // Working registers of the current request.
    logic          op_reg, op_next;
    logic [31:0]   addr_reg, addr_next;
    logic [32:0]   need_reg, need_next;
    logic [32:0]   nm1_reg, nm1_next;
    logic          needz_reg, needz_next;
    logic [31:0]   base_hdr_reg, base_hdr_next;
    logic [31:0]   off_reg, off_next;
    logic [NW-1:0] n_reg, n_next;
    logic [LVW-1:0] lvl_reg, lvl_next;
    logic [LVW-1:0] k_reg, k_next;
    logic          kok_reg, kok_next;
    logic [LVW-1:0] cur_reg, cur_next;
    logic [LFW-1:0] pos_reg, pos_next;
    logic [MW-1:0] curmask_reg, curmask_next;
    bba_pkg::status_t res_status_reg, res_status_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [OW-1:0] res_order_reg, res_order_next;
    bba_pkg::status_t m_tuser_reg, m_tuser_next;
    logic [39:0]   m_tdata_reg, m_tdata_next;

    // Memory ports.
    logic          mask_we;
    logic [NW-1:0] mask_waddr, mask_raddr;
    logic [MW-1:0] mask_wdata, mask_rdata;
    logic          ord_we;
    logic [LFW-1:0] ord_waddr, ord_raddr;
    logic [OW-1:0] ord_wdata, ord_rdata;

    // Node tree memory: one order mask per node.
    bba_ram #(.DW(MW), .AW(NW), .DEPTH(NODES)) u_tree_mem (
        .aclk  (aclk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    // Allocated order per minimum-sized slot; zero means nothing starts there.
    bba_ram #(.DW(OW), .AW(LFW), .DEPTH(LEAVES)) u_order_mem (
        .aclk  (aclk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    // Orders that fit the request plus header, indexed from MIN_ORDER.
    logic [MW-1:0]  fits;
    logic [LVW-1:0] fit_lvl;
    logic           fit_ok;
    always_comb begin
        for (int i = 0; i < MW; i++) begin
            fits[i] = needz_reg || ((nm1_reg >> (MIN_ORDER + i)) == 33'd0);
        end
        fit_lvl = '0;
        for (int i = MW - 1; i >= 0; i--) begin
            if (fits[i]) begin
                fit_lvl = LVW'(i);
            end
        end
        fit_ok = |fits;
    end

    // Lowest free order at or above the fitting order, from the root mask.
    logic [MW-1:0]  cand;
    logic [LVW-1:0] cand_lvl;
    always_comb begin
        cand     = mask_rdata & ~((MW'(1) << k_reg) - MW'(1));
        cand_lvl = '0;
        for (int i = MW - 1; i >= 0; i--) begin
            if (cand[i]) begin
                cand_lvl = LVW'(i);
            end
        end
    end

    // Tree navigation helpers.
    logic [NW-1:0]  child_l, child_r, sib, parent;
    logic [LVW-1:0] lvl_dn, lvl_up;
    logic [31:0]    off_bytes;
    logic [LFW-1:0] leaf;
    logic [OW-1:0]  ord_sh;
    logic [LFW-1:0] ord_low;
    logic [NW-1:0]  first_node;
    logic           ord_ok;
    always_comb begin
        child_l    = {n_reg[NW-2:0], 1'b1};
        child_r    = child_l + NW'(1);
        sib        = n_reg[0] ? (n_reg + NW'(1)) : (n_reg - NW'(1));
        parent     = (n_reg - NW'(1)) >> 1;
        lvl_dn     = lvl_reg - LVW'(1);
        lvl_up     = lvl_reg + LVW'(1);
        off_bytes  = 32'(pos_reg) << MIN_ORDER;
        leaf       = off_reg[MIN_ORDER +: LFW];
        ord_sh     = ord_rdata - OW'(MIN_ORDER);
        ord_low    = ~({LFW{1'b1}} << ord_sh);
        first_node = (NW'(1) << (LEVELS - int'(ord_sh))) - NW'(1);
        ord_ok     = (ord_rdata >= OW'(MIN_ORDER)) && (ord_rdata <= OW'(HEAP_ORDER))
                     && ((leaf & ord_low) == '0);
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        m_tvalid_next   = m_tvalid_reg;
        heap_base_next  = heap_base_reg;
        header_next     = header_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        need_next       = need_reg;
        nm1_next        = nm1_reg;
        needz_next      = needz_reg;
        base_hdr_next   = base_hdr_reg;
        off_next        = off_reg;
        n_next          = n_reg;
        lvl_next        = lvl_reg;
        k_next          = k_reg;
        kok_next        = kok_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        curmask_next    = curmask_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_order_next  = res_order_reg;
        m_tuser_next    = m_tuser_reg;
        m_tdata_next    = m_tdata_reg;
        mask_we         = 1'b0;
        mask_waddr      = '0;
        mask_wdata      = '0;
        mask_raddr      = '0;
        ord_we          = 1'b0;
        ord_waddr       = '0;
        ord_wdata       = '0;
        ord_raddr       = '0;

        // Writes to any other index are ignored.
        if (cfg_wr_en) begin
            if (cfg_index == bba_pkg::CFG_HEAP_BASE) begin
                heap_base_next = cfg_wr_data;
            end else if (cfg_index == bba_pkg::CFG_HEADER_BYTES) begin
                header_next = cfg_wr_data[6:0];
            end
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                // Root starts free as a whole; everything under it is never read
                // before being written. The order memory is swept to zero.
                ord_we    = 1'b1;
                ord_waddr = clr_reg[LFW-1:0];
                if (clr_reg == '0) begin
                    mask_we    = 1'b1;
                    mask_waddr = '0;
                    mask_wdata = MW'(1) << LEVELS;
                end
                clr_next = clr_reg + CW'(1);
                if (clr_reg == CW'(LEAVES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next         = s_tuser[0];
                    addr_next       = s_tdata[63:32];
                    need_next       = {1'b0, s_tdata[31:0]} + 33'(header_reg);
                    base_hdr_next   = heap_base_reg + 32'(header_reg);
                    res_status_next = bba_pkg::ST_OK;
                    res_addr_next   = '0;
                    res_order_next  = '0;
                    state_next      = S_PREP;
                end
            end
            S_PREP: begin
                nm1_next   = need_reg - 33'd1;
                needz_next = (need_reg == 33'd0);
                off_next   = addr_reg - base_hdr_reg;
                state_next = (op_reg == bba_pkg::OP_FREE) ? S_FCHK : S_AFIT;
            end
            S_AFIT: begin
                k_next     = fit_lvl;
                kok_next   = fit_ok;
                mask_raddr = '0;
                state_next = S_AROOT;
            end
            S_AROOT: begin
                if (!kok_reg || (cand == '0)) begin
                    res_status_next = bba_pkg::ST_NO_SPACE;
                    state_next      = S_FIN;
                end else begin
                    cur_next   = cand_lvl;
                    n_next     = '0;
                    lvl_next   = LVW'(LEVELS);
                    pos_next   = '0;
                    state_next = (cand_lvl == LVW'(LEVELS)) ? S_SPLIT : S_DESC;
                end
            end
            S_DESC: begin
                mask_raddr = child_l;
                state_next = S_DESCW;
            end
            S_DESCW: begin
                // Prefer the lower half when it holds a free block of the target order.
                if (mask_rdata[cur_reg]) begin
                    n_next = child_l;
                end else begin
                    n_next   = child_r;
                    pos_next = pos_reg | (LFW'(1) << lvl_dn);
                end
                lvl_next   = lvl_dn;
                state_next = (lvl_dn == cur_reg) ? S_SPLIT : S_DESC;
            end
            S_SPLIT: begin
                if (lvl_reg != k_reg) begin
                    // Upper half becomes a free block, continue in the lower half.
                    mask_we    = 1'b1;
                    mask_waddr = child_r;
                    mask_wdata = MW'(1) << lvl_dn;
                    n_next     = child_l;
                    lvl_next   = lvl_dn;
                end else begin
                    mask_we         = 1'b1;
                    mask_waddr      = n_reg;
                    mask_wdata      = '0;
                    curmask_next    = '0;
                    ord_we          = 1'b1;
                    ord_waddr       = pos_reg;
                    ord_wdata       = OW'(lvl_reg) + OW'(MIN_ORDER);
                    res_addr_next   = base_hdr_reg + off_bytes;
                    res_order_next  = OW'(lvl_reg) + OW'(MIN_ORDER);
                    state_next      = (n_reg == '0) ? S_FIN : S_UPRD;
                end
            end
            S_UPRD: begin
                mask_raddr = sib;
                state_next = S_UPWR;
            end
            S_UPWR: begin
                // Ancestors of a block are never free themselves: their mask is the
                // union of the two children.
                mask_we      = 1'b1;
                mask_waddr   = parent;
                mask_wdata   = curmask_reg | mask_rdata;
                curmask_next = curmask_reg | mask_rdata;
                n_next       = parent;
                state_next   = (parent == '0) ? S_FIN : S_UPRD;
            end
            S_FCHK: begin
                if (((off_reg >> HEAP_ORDER) != 32'd0) || (off_reg[MIN_ORDER-1:0] != '0)) begin
                    res_status_next = bba_pkg::ST_BAD_FREE;
                    state_next      = S_FIN;
                end else begin
                    ord_raddr  = leaf;
                    state_next = S_FORD;
                end
            end
            S_FORD: begin
                if (!ord_ok) begin
                    res_status_next = bba_pkg::ST_BAD_FREE;
                    state_next      = S_FIN;
                end else begin
                    ord_we         = 1'b1;
                    ord_waddr      = leaf;
                    ord_wdata      = '0;
                    res_order_next = ord_rdata;
                    lvl_next       = LVW'(ord_sh);
                    n_next         = first_node + (NW'(leaf) >> ord_sh);
                    state_next     = S_MRD;
                end
            end
            S_MRD: begin
                if (n_reg == '0) begin
                    state_next = S_MSET;
                end else begin
                    mask_raddr = sib;
                    state_next = S_MWR;
                end
            end
            S_MWR: begin
                // A free buddy is absorbed; its subtree is left as it is.
                if (mask_rdata[lvl_reg]) begin
                    n_next     = parent;
                    lvl_next   = lvl_up;
                    state_next = S_MRD;
                end else begin
                    state_next = S_MSET;
                end
            end
            S_MSET: begin
                mask_we      = 1'b1;
                mask_waddr   = n_reg;
                mask_wdata   = MW'(1) << lvl_reg;
                curmask_next = MW'(1) << lvl_reg;
                state_next   = (n_reg == '0) ? S_FIN : S_UPRD;
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {3'd0, res_order_reg, res_addr_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            heap_base_reg <= '0;
            header_reg    <= bba_pkg::HEADER_RESET;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            m_tvalid_reg  <= m_tvalid_next;
            heap_base_reg <= heap_base_next;
            header_reg    <= header_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        need_reg       <= need_next;
        nm1_reg        <= nm1_next;
        needz_reg      <= needz_next;
        base_hdr_reg   <= base_hdr_next;
        off_reg        <= off_next;
        n_reg          <= n_next;
        lvl_reg        <= lvl_next;
        k_reg          <= k_next;
        kok_reg        <= kok_next;
        cur_reg        <= cur_next;
        pos_reg        <= pos_next;
        curmask_reg    <= curmask_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_order_reg  <= res_order_next;
        m_tuser_reg    <= m_tuser_next;
        m_tdata_reg    <= m_tdata_next;
    end

`ifndef ASSERT_OFF
    // A split never goes below the order the request needs.
    a_split_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SPLIT) |-> (lvl_reg >= k_reg))
        else $error("split below requested order");

    // A successful result names an order inside the heap's range.
    a_ok_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tuser_reg == bba_pkg::ST_OK)) |->
        ((m_tdata_reg[36:32] >= OW'(MIN_ORDER)) && (m_tdata_reg[36:32] <= OW'(HEAP_ORDER))))
        else $error("granted order out of range");

    // A failed request carries neither an address nor an order.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tuser_reg != bba_pkg::ST_OK)) |-> (m_tdata_reg == 40'd0))
        else $error("failed request carries data");

    // No request is taken while the order memory is being cleared.
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |=> !(s_tvalid && s_tready && ($past(state_reg) == S_CLEAR)
        && (state_reg == S_CLEAR)))
        else $error("request accepted during clear");
`endif

endmodule

`default_nettype wire

// ===== dv/buddy_block_allocator_test.sv =====
// Self-checking testbench for the buddy block allocator.
`timescale 1ns / 1ps

module buddy_block_allocator_test;

    localparam int HEAP_ORD  = 16;
    localparam int MIN_ORD   = 5;
    localparam int LEVELS    = HEAP_ORD - MIN_ORD;
    localparam int SLOTS     = 1 << LEVELS;
    localparam int NODES     = 2 * SLOTS - 1;
    localparam int WATCHDOG  = 20000;

    // A register index that the block ignores.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic        op;
        logic [31:0] req_bytes;
        logic [31:0] free_addr;
    } request_t;

    typedef struct packed {
        bba_pkg::status_t status;
        logic [31:0]      addr;
        logic [4:0]       order;
    } outcome_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0] m_tuser;

    buddy_block_allocator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #6 aclk = ~aclk;

    // Shadow allocator state, updated when an item is accepted or a register is written.
    logic [31:0] heap_base_sh;
    logic [6:0]  header_sh;
    bit          free_node[NODES];
    logic [4:0]  slot_order[SLOTS];

    request_t pending_reqs[$];
    outcome_t awaited[$];
    logic [31:0] live_addrs[$];   // payload addresses currently granted
    int errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 7;
    int recv_idle_pct = 62;
    bit hold_send = 1'b0;

    // Whether the item on the bus was taken at the last rising edge.
    logic s_tready_q = 1'b0;

    function automatic int level_base(int order);
        return (1 << (HEAP_ORD - order)) - 1;
    endfunction

    // Computes the allocator's answer to one request and updates the shadow state.
    function automatic outcome_t allocate_or_free(request_t r);
        outcome_t o;
        logic [32:0] need;
        int k, cur, n, i;
        bit found;
        logic [31:0] off;
        int ord;
        o = '0;
        if (r.op == bba_pkg::OP_ALLOC) begin
            need = {1'b0, r.req_bytes} + 33'(header_sh);
            k = MIN_ORD;
            while (k <= HEAP_ORD && (33'd1 << k) < need) k++;
            if (k > HEAP_ORD) begin
                o.status = bba_pkg::ST_NO_SPACE;
                return o;
            end
            found = 1'b0;
            for (cur = k; cur <= HEAP_ORD; cur++) begin
                for (i = 0; i < (1 << (HEAP_ORD - cur)); i++) begin
                    if (free_node[level_base(cur) + i]) begin
                        n = level_base(cur) + i;
                        found = 1'b1;
                        break;
                    end
                end
                if (found) break;
            end
            if (!found) begin
                o.status = bba_pkg::ST_NO_SPACE;
                return o;
            end
            // Split down, keeping the lower half and freeing the upper one.
            while (cur > k) begin
                free_node[n] = 1'b0;
                free_node[2 * n + 2] = 1'b1;
                n = 2 * n + 1;
                cur--;
            end
            free_node[n] = 1'b0;
            off = (n - level_base(k)) << k;
            slot_order[off >> MIN_ORD] = k[4:0];
            o.status = bba_pkg::ST_OK;
            o.addr = heap_base_sh + off + 32'(header_sh);
            o.order = k[4:0];
        end else begin
            off = r.free_addr - 32'(header_sh) - heap_base_sh;
            if ((off >> HEAP_ORD) != 0 || off[MIN_ORD-1:0] != 0) begin
                o.status = bba_pkg::ST_BAD_FREE;
                return o;
            end
            ord = slot_order[off >> MIN_ORD];
            if (ord < MIN_ORD || ord > HEAP_ORD || (off & ((32'd1 << ord) - 1)) != 0) begin
                o.status = bba_pkg::ST_BAD_FREE;
                return o;
            end
            slot_order[off >> MIN_ORD] = '0;
            o.status = bba_pkg::ST_OK;
            o.order = ord[4:0];
            // Merge with the buddy while it is free as a whole.
            n = level_base(ord) + (off >> ord);
            while (n > 0) begin
                i = n[0] ? n + 1 : n - 1;
                if (!free_node[i]) break;
                free_node[i] = 1'b0;
                n = (n - 1) / 2;
            end
            free_node[n] = 1'b1;
        end
        return o;
    endfunction

    // Driver: presents queued items at the falling edge, honoring the idle rate.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_q) begin
                if (pending_reqs.size() > 0 && !hold_send &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_reqs[0].op;
                    s_tdata <= {pending_reqs[0].free_addr, pending_reqs[0].req_bytes};
                    void'(pending_reqs.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts on acceptance, checks each result item in order.
    always @(posedge aclk) begin
        outcome_t got, want;
        s_tready_q <= s_tvalid && s_tready;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (s_tvalid && s_tready) begin
                want = allocate_or_free(request_t'{s_tuser[0], s_tdata[31:0], s_tdata[63:32]});
                awaited.push_back(want);
                if (s_tuser[0] == bba_pkg::OP_ALLOC && want.status == bba_pkg::ST_OK)
                    live_addrs.push_back(want.addr);
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.addr = m_tdata[31:0];
                got.order = m_tdata[36:32];
                if (awaited.size() == 0) begin
                    $display("%0t: unexpected result item status=%0d addr=%h order=%0d",
                             $realtime, got.status, got.addr, got.order);
                    errors++;
                end else begin
                    want = awaited.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, got.status);
                        errors++;
                    end
                    if (got.addr !== want.addr) begin
                        $display("%0t: address expected %h actual %h",
                                 $realtime, want.addr, got.addr);
                        errors++;
                    end
                    if (got.order !== want.order) begin
                        $display("%0t: order expected %0d actual %0d",
                                 $realtime, want.order, got.order);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic push_alloc(input logic [31:0] bytes);
        pending_reqs.push_back(request_t'{bba_pkg::OP_ALLOC, bytes, $urandom()});
    endtask

    task automatic push_free(input logic [31:0] addr);
        pending_reqs.push_back(request_t'{bba_pkg::OP_FREE, $urandom(), addr});
    endtask

    // Waits until every queued item is taken and every result has arrived.
    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || awaited.size() > 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == bba_pkg::CFG_HEAP_BASE) heap_base_sh = value;
        else if (idx == bba_pkg::CFG_HEADER_BYTES) header_sh = value[6:0];
    endtask

    // Live addresses are known only once the allocations ahead have been predicted.
    task automatic drain_if_unknown();
        if (pending_reqs.size() > 0 && $urandom_range(3) == 0) begin
            while (pending_reqs.size() > 0) @(posedge aclk);
        end
    endtask

    // One random phase: mostly sized allocations and frees of live blocks, some noise.
    task automatic random_phase(input int count);
        int pick, idx;
        logic [31:0] bytes;
        for (int j = 0; j < count; j++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                // Most requests are small; a few reach the whole heap or overflow.
                case ($urandom_range(9))
                    0: bytes = $urandom();
                    1: bytes = $urandom_range(1 << HEAP_ORD);
                    default: bytes = $urandom_range(1 << ($urandom_range(5, 11)));
                endcase
                push_alloc(bytes);
            end else if (pick < 88 && live_addrs.size() + j > 0) begin
                // Free a granted block picked at random among the known ones.
                drain_if_unknown();
                if (live_addrs.size() > 0) begin
                    idx = $urandom_range(live_addrs.size() - 1);
                    push_free(live_addrs[idx]);
                    live_addrs.delete(idx);
                end else push_alloc($urandom_range(200));
            end else begin
                case ($urandom_range(2))
                    0: push_free($urandom());
                    1: push_free(heap_base_sh + 32'(header_sh) + ($urandom_range(2047) << MIN_ORD));
                    default: push_free(heap_base_sh + 32'(header_sh) + $urandom_range(65535));
                endcase
            end
        end
        drain();
    endtask

    initial begin
        heap_base_sh = '0;
        header_sh = bba_pkg::HEADER_RESET;
        foreach (free_node[i]) free_node[i] = 1'b0;
        free_node[0] = 1'b1;
        foreach (slot_order[i]) slot_order[i] = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: extremes of sizes, invalid frees, double free, exhaustion.
        push_alloc(32'd0);
        push_alloc(32'd16);
        push_alloc(32'd17);
        push_alloc(32'hFFFF_FFFF);
        push_alloc(32'd65520);
        push_free(32'd0);
        push_free(32'hFFFF_FFFF);
        push_free(32'd17);
        drain();
        push_free(live_addrs[0]);
        push_free(live_addrs[0]);
        push_free(live_addrs[1]);
        live_addrs.delete();
        push_alloc(32'd65520);
        push_alloc(32'd0);
        drain();
        push_free(live_addrs[0]);
        live_addrs.delete();
        push_alloc(32'd65521);
        drain();

        // Pause the sender until every result is in, with the other side stalling.
        hold_send = 1'b1;
        random_phase(0);
        hold_send = 1'b0;

        write_reg(bba_pkg::CFG_HEAP_BASE, 32'hFFFF_0000);
        write_reg(bba_pkg::CFG_HEADER_BYTES, 32'd64);
        write_reg(CFG_UNUSED, 32'h1234_5678);
        random_phase(300);
        write_reg(bba_pkg::CFG_HEADER_BYTES, 32'd127);
        random_phase(200);

        send_idle_pct = 62;
        recv_idle_pct = 7;
        write_reg(bba_pkg::CFG_HEAP_BASE, 32'h0001_0000);
        write_reg(bba_pkg::CFG_HEADER_BYTES, 32'd0);
        random_phase(300);
        write_reg(bba_pkg::CFG_HEAP_BASE, 32'h0000_0000);
        write_reg(bba_pkg::CFG_HEADER_BYTES, 32'd16);
        random_phase(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(bba_pkg::CFG_HEAP_BASE, 32'hABCD_0000);
        write_reg(bba_pkg::CFG_HEADER_BYTES, 32'd1);
        random_phase(600);

        drain();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/buddy_block_allocator.sv
dv/buddy_block_allocator_test.sv
